FILE: rtl/emr_pkg.sv
`default_nettype none

package emr_pkg;

    // Field widths
    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 11;
    localparam int OUT_BITS    = 13;

    // Datapath widths
    localparam int SQ_BITS    = 2 * RADIUS_BITS;      // a^2, b^2
    localparam int UV_BITS    = 3 * RADIUS_BITS + 3;  // 8*b^2*x, 8*a^2*y
    localparam int DEC_BITS   = 4 * RADIUS_BITS + 8;  // decision, product register
    localparam int MUL_A_BITS = 3 * RADIUS_BITS + 1;  // wide multiplier operand
    localparam int MUL_B_BITS = 2 * RADIUS_BITS;      // narrow multiplier operand
    localparam int TX_BITS    = RADIUS_BITS + 1;      // 2x+1

    localparam int UPC_BITS = 5;

    // Multiplier operand selection
    typedef enum logic [3:0] {
        MS_NONE = 4'd0,
        MS_AA   = 4'd1,
        MS_BB   = 4'd2,
        MS_A2B  = 4'd3,
        MS_B2TX = 4'd4,
        MS_PTX  = 4'd5,
        MS_A2TY = 4'd6,
        MS_PTY  = 4'd7,
        MS_A2B2 = 4'd8
    } mul_sel_t;

    // Decision register operations
    typedef enum logic [2:0] {
        D_HOLD  = 3'd0,
        D_INIT  = 3'd1,
        D_LOADP = 3'd2,
        D_ADD4P = 3'd3,
        D_SUB4P = 3'd4,
        D_R1    = 3'd5,
        D_R2    = 3'd6
    } d_op_t;

    typedef enum logic [1:0] {
        EM_NONE  = 2'd0,
        EM_POINT = 2'd1,
        EM_NULL  = 2'd2
    } emit_t;

    // Jump conditions of the sequencer
    typedef enum logic [2:0] {
        C_NEVER    = 3'd0,
        C_ALWAYS   = 3'd1,
        C_NO_INPUT = 3'd2,
        C_REQ_STEP = 3'd3,
        C_IDLE     = 3'd4,
        C_REGION2  = 3'd5,
        C_R1_OK    = 3'd6
    } cond_t;

    typedef struct packed {
        mul_sel_t mul_sel;
        d_op_t    d_op;
        logic     ld_a2;
        logic     ld_b2;
        logic     ld_start;
        logic     set_in2;
        emit_t    emit;
    } ctrl_t;

    typedef struct packed {
        logic                take_in;
        cond_t               cond;
        logic [UPC_BITS-1:0] target;
        ctrl_t               ctrl;
    } uword_t;

    typedef struct packed {
        logic req_step;
        logic busy;
        logic in_two;
        logic r1_ok;
    } stat_t;

    // Program addresses
    localparam logic [UPC_BITS-1:0] UA_WAIT     = UPC_BITS'(0);
    localparam logic [UPC_BITS-1:0] UA_DISPATCH = UPC_BITS'(1);
    localparam logic [UPC_BITS-1:0] UA_SQ_A     = UPC_BITS'(2);
    localparam logic [UPC_BITS-1:0] UA_SQ_B     = UPC_BITS'(3);
    localparam logic [UPC_BITS-1:0] UA_LD_B2    = UPC_BITS'(4);
    localparam logic [UPC_BITS-1:0] UA_A2B      = UPC_BITS'(5);
    localparam logic [UPC_BITS-1:0] UA_LD_START = UPC_BITS'(6);
    localparam logic [UPC_BITS-1:0] UA_STEP     = UPC_BITS'(7);
    localparam logic [UPC_BITS-1:0] UA_CHK_R2   = UPC_BITS'(8);
    localparam logic [UPC_BITS-1:0] UA_CHK_R1   = UPC_BITS'(9);
    localparam logic [UPC_BITS-1:0] UA_RI0      = UPC_BITS'(10);
    localparam logic [UPC_BITS-1:0] UA_RI1      = UPC_BITS'(11);
    localparam logic [UPC_BITS-1:0] UA_RI2      = UPC_BITS'(12);
    localparam logic [UPC_BITS-1:0] UA_RI3      = UPC_BITS'(13);
    localparam logic [UPC_BITS-1:0] UA_RI4      = UPC_BITS'(14);
    localparam logic [UPC_BITS-1:0] UA_RI5      = UPC_BITS'(15);
    localparam logic [UPC_BITS-1:0] UA_R2       = UPC_BITS'(16);
    localparam logic [UPC_BITS-1:0] UA_EMIT     = UPC_BITS'(17);
    localparam logic [UPC_BITS-1:0] UA_R1       = UPC_BITS'(18);
    localparam logic [UPC_BITS-1:0] UA_NULL     = UPC_BITS'(19);

    // Control store
    function automatic uword_t ucode_rom(input logic [UPC_BITS-1:0] addr);
        uword_t uw;
        uw = '0;
        case (addr)
            UA_WAIT:
            begin
                uw.take_in = 1'b1;
                uw.cond    = C_NO_INPUT;
                uw.target  = UA_WAIT;
            end
            UA_DISPATCH:
            begin
                uw.cond   = C_REQ_STEP;
                uw.target = UA_STEP;
            end
            UA_SQ_A:
            begin
                uw.ctrl.mul_sel = MS_AA;
            end
            UA_SQ_B:
            begin
                uw.ctrl.ld_a2   = 1'b1;
                uw.ctrl.mul_sel = MS_BB;
            end
            UA_LD_B2:
            begin
                uw.ctrl.ld_b2 = 1'b1;
            end
            UA_A2B:
            begin
                uw.ctrl.mul_sel = MS_A2B;
                uw.ctrl.d_op    = D_INIT;
            end
            UA_LD_START:
            begin
                uw.ctrl.d_op     = D_SUB4P;
                uw.ctrl.ld_start = 1'b1;
                uw.cond          = C_ALWAYS;
                uw.target        = UA_EMIT;
            end
            UA_STEP:
            begin
                uw.cond   = C_IDLE;
                uw.target = UA_NULL;
            end
            UA_CHK_R2:
            begin
                uw.cond   = C_REGION2;
                uw.target = UA_R2;
            end
            UA_CHK_R1:
            begin
                uw.cond   = C_R1_OK;
                uw.target = UA_R1;
            end
            UA_RI0:
            begin
                uw.ctrl.mul_sel = MS_B2TX;
                uw.ctrl.set_in2 = 1'b1;
            end
            UA_RI1:
            begin
                uw.ctrl.mul_sel = MS_PTX;
            end
            UA_RI2:
            begin
                uw.ctrl.d_op    = D_LOADP;
                uw.ctrl.mul_sel = MS_A2TY;
            end
            UA_RI3:
            begin
                uw.ctrl.mul_sel = MS_PTY;
            end
            UA_RI4:
            begin
                uw.ctrl.d_op    = D_ADD4P;
                uw.ctrl.mul_sel = MS_A2B2;
            end
            UA_RI5:
            begin
                uw.ctrl.d_op = D_SUB4P;
            end
            UA_R2:
            begin
                uw.ctrl.d_op = D_R2;
            end
            UA_EMIT:
            begin
                uw.ctrl.emit = EM_POINT;
                uw.cond      = C_ALWAYS;
                uw.target    = UA_WAIT;
            end
            UA_R1:
            begin
                uw.ctrl.d_op = D_R1;
                uw.cond      = C_ALWAYS;
                uw.target    = UA_EMIT;
            end
            UA_NULL:
            begin
                uw.ctrl.emit = EM_NULL;
                uw.cond      = C_ALWAYS;
                uw.target    = UA_WAIT;
            end
            default:
            begin
                uw.cond   = C_ALWAYS;
                uw.target = UA_WAIT;
            end
        endcase
        return uw;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/emr_datapath.sv
`default_nettype none

module emr_datapath (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire emr_pkg::ctrl_t                    ctrl,
    input  wire logic                              cap_en,
    input  wire logic                              req_type,
    input  wire logic [emr_pkg::COORD_BITS-1:0]    center_x,
    input  wire logic [emr_pkg::COORD_BITS-1:0]    center_y,
    input  wire logic [emr_pkg::RADIUS_BITS-1:0]   radius_a,
    input  wire logic [emr_pkg::RADIUS_BITS-1:0]   radius_b,
    output emr_pkg::stat_t                         stat,
    output logic signed [emr_pkg::OUT_BITS-1:0]    x_plus,
    output logic signed [emr_pkg::OUT_BITS-1:0]    x_minus,
    output logic signed [emr_pkg::OUT_BITS-1:0]    y_plus,
    output logic signed [emr_pkg::OUT_BITS-1:0]    y_minus,
    output logic                                   last_point
);
    import emr_pkg::*;

    // Control state
    logic req_reg, req_next;
    logic in2_reg, in2_next;
    logic busy_reg, busy_next;

    // Payload state
    logic [COORD_BITS-1:0]  cx_reg, cx_next;
    logic [COORD_BITS-1:0]  cy_reg, cy_next;
    logic [RADIUS_BITS-1:0] ra_reg, ra_next;
    logic [RADIUS_BITS-1:0] rb_reg, rb_next;
    logic [SQ_BITS-1:0]     a2_reg, a2_next;
    logic [SQ_BITS-1:0]     b2_reg, b2_next;
    logic [RADIUS_BITS-1:0] x_reg, x_next;
    logic [RADIUS_BITS-1:0] y_reg, y_next;
    logic [UV_BITS-1:0]     u_reg, u_next;
    logic [UV_BITS-1:0]     v_reg, v_next;
    logic [DEC_BITS-1:0]    d_reg, d_next;
    logic [DEC_BITS-1:0]    p_reg, p_next;

    // Step terms
    logic                         x_sat;
    logic [RADIUS_BITS-1:0]       x_inc;
    logic [UV_BITS-1:0]           u_inc;
    logic [RADIUS_BITS-1:0]       y_dec;
    logic [UV_BITS-1:0]           v_dec;
    logic                         d_neg;
    logic                         d_pos;
    logic [DEC_BITS-1:0]          a2_x4;
    logic [DEC_BITS-1:0]          b2_x4;
    logic [DEC_BITS-1:0]          p_x4;
    logic [TX_BITS-1:0]           tx;
    logic [MUL_A_BITS-1:0]        mul_a;
    logic [MUL_B_BITS-1:0]        mul_b;
    logic [MUL_A_BITS+MUL_B_BITS-1:0] mul_prod;

    // Saturating x advance with its tracked 8*b^2*x
    assign x_sat = (x_reg == {RADIUS_BITS{1'b1}});
    assign x_inc = x_sat ? x_reg : x_reg + RADIUS_BITS'(1);
    assign u_inc = x_sat ? u_reg : u_reg + (UV_BITS'(b2_reg) << 3);

    // y retreat with its tracked 8*a^2*y
    assign y_dec = y_reg - RADIUS_BITS'(1);
    assign v_dec = v_reg - (UV_BITS'(a2_reg) << 3);

    assign d_neg = d_reg[DEC_BITS-1];
    assign d_pos = !d_neg && (d_reg != '0);

    assign a2_x4 = DEC_BITS'(a2_reg) << 2;
    assign b2_x4 = DEC_BITS'(b2_reg) << 2;
    assign p_x4  = p_reg << 2;
    assign tx    = {x_reg, 1'b1};

    // Select multiplier operands
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.mul_sel)
            MS_AA:
            begin
                mul_a = MUL_A_BITS'(ra_reg);
                mul_b = MUL_B_BITS'(ra_reg);
            end
            MS_BB:
            begin
                mul_a = MUL_A_BITS'(rb_reg);
                mul_b = MUL_B_BITS'(rb_reg);
            end
            MS_A2B:
            begin
                mul_a = MUL_A_BITS'(a2_reg);
                mul_b = MUL_B_BITS'(rb_reg);
            end
            MS_B2TX:
            begin
                mul_a = MUL_A_BITS'(b2_reg);
                mul_b = MUL_B_BITS'(tx);
            end
            MS_PTX:
            begin
                mul_a = p_reg[MUL_A_BITS-1:0];
                mul_b = MUL_B_BITS'(tx);
            end
            MS_A2TY:
            begin
                mul_a = MUL_A_BITS'(a2_reg);
                mul_b = MUL_B_BITS'(y_dec);
            end
            MS_PTY:
            begin
                mul_a = p_reg[MUL_A_BITS-1:0];
                mul_b = MUL_B_BITS'(y_dec);
            end
            MS_A2B2:
            begin
                mul_a = MUL_A_BITS'(a2_reg);
                mul_b = MUL_B_BITS'(b2_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_prod = (MUL_A_BITS+MUL_B_BITS)'(mul_a) * (MUL_A_BITS+MUL_B_BITS)'(mul_b);

    // Product register and squared radii
    always_comb
    begin
        p_next  = (ctrl.mul_sel == MS_NONE) ? p_reg : DEC_BITS'(mul_prod);
        a2_next = ctrl.ld_a2 ? SQ_BITS'(p_reg) : a2_reg;
        b2_next = ctrl.ld_b2 ? SQ_BITS'(p_reg) : b2_reg;
    end

    // Decision value
    always_comb
    begin
        d_next = d_reg;
        case (ctrl.d_op)
            D_INIT:  d_next = DEC_BITS'(a2_reg) + b2_x4;
            D_LOADP: d_next = p_reg;
            D_ADD4P: d_next = d_reg + p_x4;
            D_SUB4P: d_next = d_reg - p_x4;
            D_R1:
            begin
                if (d_neg)
                    d_next = d_reg + DEC_BITS'(u_inc) + b2_x4;
                else
                    d_next = d_reg + DEC_BITS'(u_inc) + b2_x4 - DEC_BITS'(v_dec);
            end
            D_R2:
            begin
                if (d_pos)
                    d_next = d_reg + a2_x4 - DEC_BITS'(v_dec);
                else
                    d_next = d_reg + DEC_BITS'(u_inc) + a2_x4 - DEC_BITS'(v_dec);
            end
            default: d_next = d_reg;
        endcase
    end

    // Offsets and their tracked products
    always_comb
    begin
        x_next = x_reg;
        y_next = y_reg;
        u_next = u_reg;
        v_next = v_reg;
        if (ctrl.ld_start)
        begin
            x_next = '0;
            y_next = rb_reg;
            u_next = '0;
            v_next = UV_BITS'(p_reg) << 3;
        end
        else if (ctrl.d_op == D_R1)
        begin
            x_next = x_inc;
            u_next = u_inc;
            if (!d_neg)
            begin
                y_next = y_dec;
                v_next = v_dec;
            end
        end
        else if (ctrl.d_op == D_R2)
        begin
            y_next = y_dec;
            v_next = v_dec;
            if (!d_pos)
            begin
                x_next = x_inc;
                u_next = u_inc;
            end
        end
    end

    // Region, busy and input capture
    always_comb
    begin
        req_next  = cap_en ? req_type : req_reg;
        cx_next   = cx_reg;
        cy_next   = cy_reg;
        ra_next   = ra_reg;
        rb_next   = rb_reg;
        in2_next  = in2_reg;
        busy_next = busy_reg;
        if (cap_en && !req_type)
        begin
            cx_next = center_x;
            cy_next = center_y;
            ra_next = radius_a;
            rb_next = radius_b;
        end
        if (ctrl.ld_start)
        begin
            in2_next  = 1'b0;
            busy_next = 1'b1;
        end
        if (ctrl.set_in2)
            in2_next = 1'b1;
        // drop busy once the last point goes out
        if (ctrl.emit == EM_POINT && y_reg == '0)
            busy_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_reg  <= 1'b0;
            in2_reg  <= 1'b0;
            busy_reg <= 1'b0;
        end
        else
        begin
            req_reg  <= req_next;
            in2_reg  <= in2_next;
            busy_reg <= busy_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cx_reg <= cx_next;
        cy_reg <= cy_next;
        ra_reg <= ra_next;
        rb_reg <= rb_next;
        a2_reg <= a2_next;
        b2_reg <= b2_next;
        x_reg  <= x_next;
        y_reg  <= y_next;
        u_reg  <= u_next;
        v_reg  <= v_next;
        d_reg  <= d_next;
        p_reg  <= p_next;
    end

    // Status toward the sequencer
    always_comb
    begin
        stat.req_step = req_reg;
        stat.busy     = busy_reg;
        stat.in_two   = in2_reg;
        stat.r1_ok    = (u_reg <= v_reg);
    end

    // Four symmetric pixels of the current point
    assign x_plus     = OUT_BITS'(cx_reg) + OUT_BITS'(x_reg);
    assign x_minus    = OUT_BITS'(cx_reg) - OUT_BITS'(x_reg);
    assign y_plus     = OUT_BITS'(cy_reg) + OUT_BITS'(y_reg);
    assign y_minus    = OUT_BITS'(cy_reg) - OUT_BITS'(y_reg);
    assign last_point = (y_reg == '0);

endmodule

`default_nettype wire

FILE: rtl/ellipse_midpoint_rasterizer.sv
`default_nettype none

// Midpoint ellipse rasterizer.
// Input channel (in_valid/in_ready): a word with req_type 0 starts an ellipse at
// (center_x, center_y) with radii radius_a, radius_b; req_type 1 asks for the next point.
// Output channel (out_valid/out_ready): one word per input word. point_valid is 1 with
// the four mirrored pixels; last_point marks the point where the y offset reaches zero,
// after which the block is idle and a step word returns point_valid 0 with zero fields.
// A start word while an ellipse is running drops it and begins the new one.
// Each kind of word takes its own path through the control program: start, region-1 step,
// region-2 step, first region-2 step (decision reload), step while idle.
// One word is in flight at a time; the next input is accepted when the control program
// returns to its wait step, after the emit step that registers the result. The microcoded
// sequencer steps a single datapath with one shared multiplier, one control word per
// cycle except while it holds at its emit step.
// The output register lets a finished word wait while the next input is taken; when the
// receiver stalls with a word still held, the program holds at its emit step.
// Reset empties the output register, clears the busy and region flags, and parks the
// program at its wait step.

module ellipse_midpoint_rasterizer (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              req_type,
    input  wire logic [emr_pkg::COORD_BITS-1:0]    center_x,
    input  wire logic [emr_pkg::COORD_BITS-1:0]    center_y,
    input  wire logic [emr_pkg::RADIUS_BITS-1:0]   radius_a,
    input  wire logic [emr_pkg::RADIUS_BITS-1:0]   radius_b,
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic                                   point_valid,
    output logic signed [emr_pkg::OUT_BITS-1:0]    x_plus,
    output logic signed [emr_pkg::OUT_BITS-1:0]    x_minus,
    output logic signed [emr_pkg::OUT_BITS-1:0]    y_plus,
    output logic signed [emr_pkg::OUT_BITS-1:0]    y_minus,
    output logic                                   last_point
);
    import emr_pkg::*;

    logic [UPC_BITS-1:0] upc_reg, upc_next;
    uword_t              uw;
    ctrl_t               ctrl_eff;
    stat_t               stat;
    logic                stall;
    logic                emit_fire;
    logic                cap_en;
    logic                jump;

    logic signed [OUT_BITS-1:0] dp_x_plus;
    logic signed [OUT_BITS-1:0] dp_x_minus;
    logic signed [OUT_BITS-1:0] dp_y_plus;
    logic signed [OUT_BITS-1:0] dp_y_minus;
    logic                       dp_last;

    logic                       out_valid_reg, out_valid_next;
    logic                       pv_reg, pv_next;
    logic signed [OUT_BITS-1:0] xp_reg, xp_next;
    logic signed [OUT_BITS-1:0] xm_reg, xm_next;
    logic signed [OUT_BITS-1:0] yp_reg, yp_next;
    logic signed [OUT_BITS-1:0] ym_reg, ym_next;
    logic                       last_reg, last_next;

    // Decode the current control word
    always_comb
    begin
        uw        = ucode_rom(upc_reg);
        stall     = (uw.ctrl.emit != EM_NONE) && out_valid_reg && !out_ready;
        emit_fire = (uw.ctrl.emit != EM_NONE) && !stall;
        ctrl_eff  = stall ? '0 : uw.ctrl;
        in_ready  = uw.take_in;
        cap_en    = in_valid && uw.take_in;
    end

    // Next step: hold on stall, else jump or advance
    always_comb
    begin
        case (uw.cond)
            C_NEVER:    jump = 1'b0;
            C_ALWAYS:   jump = 1'b1;
            C_NO_INPUT: jump = !in_valid;
            C_REQ_STEP: jump = stat.req_step;
            C_IDLE:     jump = !stat.busy;
            C_REGION2:  jump = stat.in_two;
            C_R1_OK:    jump = stat.r1_ok;
            default:    jump = 1'b1;
        endcase
        if (stall)
            upc_next = upc_reg;
        else if (jump)
            upc_next = uw.target;
        else
            upc_next = upc_reg + UPC_BITS'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            upc_reg <= UA_WAIT;
        else
            upc_reg <= upc_next;
    end

    emr_datapath u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (ctrl_eff),
        .cap_en     (cap_en),
        .req_type   (req_type),
        .center_x   (center_x),
        .center_y   (center_y),
        .radius_a   (radius_a),
        .radius_b   (radius_b),
        .stat       (stat),
        .x_plus     (dp_x_plus),
        .x_minus    (dp_x_minus),
        .y_plus     (dp_y_plus),
        .y_minus    (dp_y_minus),
        .last_point (dp_last)
    );

    // Output register: load on emit, drop when taken
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        pv_next        = pv_reg;
        xp_next        = xp_reg;
        xm_next        = xm_reg;
        yp_next        = yp_reg;
        ym_next        = ym_reg;
        last_next      = last_reg;
        if (emit_fire)
        begin
            out_valid_next = 1'b1;
            if (uw.ctrl.emit == EM_POINT)
            begin
                pv_next   = 1'b1;
                xp_next   = dp_x_plus;
                xm_next   = dp_x_minus;
                yp_next   = dp_y_plus;
                ym_next   = dp_y_minus;
                last_next = dp_last;
            end
            else
            begin
                pv_next   = 1'b0;
                xp_next   = '0;
                xm_next   = '0;
                yp_next   = '0;
                ym_next   = '0;
                last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        pv_reg   <= pv_next;
        xp_reg   <= xp_next;
        xm_reg   <= xm_next;
        yp_reg   <= yp_next;
        ym_reg   <= ym_next;
        last_reg <= last_next;
    end

    assign out_valid   = out_valid_reg;
    assign point_valid = pv_reg;
    assign x_plus      = xp_reg;
    assign x_minus     = xm_reg;
    assign y_plus      = yp_reg;
    assign y_minus     = ym_reg;
    assign last_point  = last_reg;

    // A point goes out only while an ellipse is running
    a_point_needs_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && uw.ctrl.emit == EM_POINT) |-> stat.busy)
        else $error("point emitted while idle");

    // The last point leaves the block idle
    a_last_clears_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_fire && uw.ctrl.emit == EM_POINT && dp_last) |=> !stat.busy)
        else $error("busy still set after last point");

    // An accepted word is dispatched next cycle
    a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> (upc_reg == UA_DISPATCH))
        else $error("accepted word not dispatched");

    // Region-1 steps never run after the switch to region 2
    a_no_r1_in_r2: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl_eff.d_op == D_R1) |-> !stat.in_two)
        else $error("region-1 step in region 2");

endmodule

`default_nettype wire

FILE: tb/sv/tb_ellipse_midpoint_rasterizer.sv
`default_nettype none

module tb_ellipse_midpoint_rasterizer;
    timeunit 1ns;
    timeprecision 1ps;

    import emr_pkg::*;

    localparam logic REQ_START = 1'b0;
    localparam logic REQ_STEP  = 1'b1;

    localparam logic [63:0] RAD_MAX   = (64'd1 << RADIUS_BITS) - 64'd1;
    localparam int          LONG_HOLD = 300;

    // One word waiting to go into the block, with the idle cycles to spend before it
    typedef struct {
        logic                   req;
        logic [COORD_BITS-1:0]  cx;
        logic [COORD_BITS-1:0]  cy;
        logic [RADIUS_BITS-1:0] ra;
        logic [RADIUS_BITS-1:0] rb;
        bit                     drain;
        int                     gap;
    } req_word_t;

    // The four mirrored pixels of one point
    typedef struct packed {
        logic                pv;
        logic [OUT_BITS-1:0] xp;
        logic [OUT_BITS-1:0] xm;
        logic [OUT_BITS-1:0] yp;
        logic [OUT_BITS-1:0] ym;
        logic                last;
    } pixel_set_t;

    // Rasterizer state, held at 64 bits so the decision value never overflows
    typedef struct {
        logic [63:0] ccol;
        logic [63:0] crow;
        logic [63:0] asq;
        logic [63:0] bsq;
        logic [63:0] ox;
        logic [63:0] oy;
        logic [63:0] dec;
        bit          in2;
        bit          busy;
    } ellipse_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                          in_valid  = 1'b0;
    logic                          in_ready;
    logic                          req_type  = REQ_STEP;
    logic [COORD_BITS-1:0]         center_x  = '0;
    logic [COORD_BITS-1:0]         center_y  = '0;
    logic [RADIUS_BITS-1:0]        radius_a  = '0;
    logic [RADIUS_BITS-1:0]        radius_b  = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    logic                          point_valid;
    logic signed [OUT_BITS-1:0]    x_plus;
    logic signed [OUT_BITS-1:0]    x_minus;
    logic signed [OUT_BITS-1:0]    y_plus;
    logic signed [OUT_BITS-1:0]    y_minus;
    logic                          last_point;

    req_word_t  words_to_send[$];
    pixel_set_t points_due[$];

    ellipse_t   plan_st;
    ellipse_t   track_st;
    pixel_set_t due_set;
    pixel_set_t got;
    pixel_set_t want;

    bit drain_next  = 1'b0;
    int calm_items  = 0;
    int drawn_items = 0;
    int faults      = 0;
    int words_seen  = 0;
    int stall_left  = 0;
    int calm_left   = 0;
    int hold_phase  = 0;

    ellipse_midpoint_rasterizer u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .center_x    (center_x),
        .center_y    (center_y),
        .radius_a    (radius_a),
        .radius_b    (radius_b),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .point_valid (point_valid),
        .x_plus      (x_plus),
        .x_minus     (x_minus),
        .y_plus      (y_plus),
        .y_minus     (y_minus),
        .last_point  (last_point)
    );

    // Mostly short gaps, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    // Form the mirrored pixels of the current point; go idle once y reaches zero
    function automatic void mirror(inout ellipse_t s, output pixel_set_t p);
        p.pv   = 1'b1;
        p.xp   = OUT_BITS'(s.ccol + s.ox);
        p.xm   = OUT_BITS'(s.ccol - s.ox);
        p.yp   = OUT_BITS'(s.crow + s.oy);
        p.ym   = OUT_BITS'(s.crow - s.oy);
        p.last = (s.oy == 64'd0);
        if (s.oy == 64'd0)
            s.busy = 1'b0;
    endfunction

    // Advance the rasterizer by one word and return the point it produces
    function automatic void ellipse_next(
        inout  ellipse_t               s,
        input  logic                   req,
        input  logic [COORD_BITS-1:0]  cx,
        input  logic [COORD_BITS-1:0]  cy,
        input  logic [RADIUS_BITS-1:0] ra,
        input  logic [RADIUS_BITS-1:0] rb,
        output pixel_set_t             p
    );
        logic [63:0] tx;
        logic [63:0] ty;
        p = '0;
        if (req == REQ_START)
        begin
            s.ccol = 64'(cx);
            s.crow = 64'(cy);
            s.asq  = 64'(ra) * 64'(ra);
            s.bsq  = 64'(rb) * 64'(rb);
            s.ox   = 64'd0;
            s.oy   = 64'(rb);
            s.dec  = 4 * s.bsq + s.asq - 4 * s.asq * 64'(rb);
            s.in2  = 1'b0;
            s.busy = 1'b1;
            mirror(s, p);
        end
        else if (s.busy)
        begin
            if (!s.in2 && s.ox * s.bsq <= s.oy * s.asq)
            begin
                // region 1: x advances unless saturated, y drops when the midpoint is outside
                if (s.ox < RAD_MAX)
                    s.ox = s.ox + 1;
                if (s.dec[63])
                    s.dec = s.dec + 4 * s.bsq * (2 * s.ox + 1);
                else
                begin
                    s.oy  = s.oy - 1;
                    s.dec = s.dec + 4 * s.bsq * (2 * s.ox + 1) - 8 * s.asq * s.oy;
                end
            end
            else
            begin
                // reload the decision value at (x+1/2, y-1) on entry to region 2
                if (!s.in2)
                begin
                    tx    = 2 * s.ox + 1;
                    ty    = s.oy - 1;
                    s.in2 = 1'b1;
                    s.dec = s.bsq * tx * tx + 4 * s.asq * ty * ty - 4 * s.asq * s.bsq;
                end
                // region 2: y always drops, x advances when the midpoint is inside
                s.oy = s.oy - 1;
                if (!s.dec[63] && s.dec != 64'd0)
                    s.dec = s.dec + 4 * s.asq - 8 * s.asq * s.oy;
                else
                begin
                    if (s.ox < RAD_MAX)
                        s.ox = s.ox + 1;
                    s.dec = s.dec + 8 * s.bsq * s.ox + 4 * s.asq - 8 * s.asq * s.oy;
                end
            end
            mirror(s, p);
        end
    endfunction

    // Queue one word, choosing its gap and tracking where the ellipse stands
    task automatic add_item(
        input logic                   req,
        input logic [COORD_BITS-1:0]  cx,
        input logic [COORD_BITS-1:0]  cy,
        input logic [RADIUS_BITS-1:0] ra,
        input logic [RADIUS_BITS-1:0] rb
    );
        req_word_t  w;
        pixel_set_t p;
        w.req      = req;
        w.cx       = cx;
        w.cy       = cy;
        w.ra       = ra;
        w.rb       = rb;
        w.drain    = drain_next;
        drain_next = 1'b0;
        if (calm_items != 0)
        begin
            w.gap      = 0;
            calm_items = calm_items - 1;
        end
        else
        begin
            w.gap = pick_idle();
            if ($urandom_range(0, 24) == 0)
                calm_items = $urandom_range(10, 40);
        end
        if (req == REQ_START || plan_st.busy)
            drawn_items = drawn_items + 1;
        ellipse_next(plan_st, req, cx, cy, ra, rb, p);
        words_to_send.push_back(w);
    endtask

    // Start an ellipse and step it until it ends or the step budget runs out
    task automatic draw_ellipse(
        input logic [COORD_BITS-1:0]  cx,
        input logic [COORD_BITS-1:0]  cy,
        input logic [RADIUS_BITS-1:0] ra,
        input logic [RADIUS_BITS-1:0] rb,
        input int                     max_steps
    );
        int n;
        add_item(REQ_START, cx, cy, ra, rb);
        n = 0;
        while (plan_st.busy && n < max_steps)
        begin
            add_item(REQ_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                     RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
            n = n + 1;
        end
    endtask

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Reset
    initial
    begin
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
    end

    // Stimulus and end of run
    initial
    begin
        int pick;
        int goal;
        int next_drain;
        plan_st  = '{default: '0};
        track_st = '{default: '0};

        // directed: idle step, corner centers and radii, early abort, region-1 ending
        add_item(REQ_STEP, '1, '1, '1, '1);
        draw_ellipse(11'd2047, 11'd0, 10'd1023, 10'd1023, 3);
        draw_ellipse(11'd0, 11'd2047, 10'd1, 10'd1, 10);
        add_item(REQ_STEP, '0, '0, '0, '0);
        draw_ellipse(11'd1000, 11'd1000, 10'd6, 10'd1, 20);
        draw_ellipse(11'd3, 11'd2040, 10'd1, 10'd6, 20);
        draw_ellipse(11'd1024, 11'd1024, 10'd1023, 10'd1, 2);
        draw_ellipse(11'd2047, 11'd2047, 10'd1, 10'd1023, 2);

        // random: mostly whole small ellipses, some aborted large ones, some noise
        goal       = drawn_items + 750;
        next_drain = drawn_items + 200;
        drain_next = 1'b1;
        while (drawn_items < goal)
        begin
            if (drawn_items >= next_drain)
            begin
                drain_next = 1'b1;
                next_drain = next_drain + 200;
            end
            pick = $urandom_range(0, 99);
            if (pick < 8)
                add_item(REQ_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom),
                         RADIUS_BITS'($urandom), RADIUS_BITS'($urandom));
            else if (pick < 20)
                draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
                             RADIUS_BITS'($urandom_range(1, 1023)),
                             RADIUS_BITS'($urandom_range(1, 1023)),
                             $urandom_range(1, 30));
            else if (pick < 30)
                draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
                             RADIUS_BITS'($urandom_range(10, 60)),
                             RADIUS_BITS'($urandom_range(10, 60)), 400);
            else
                draw_ellipse(COORD_BITS'($urandom), COORD_BITS'($urandom),
                             RADIUS_BITS'($urandom_range(1, 12)),
                             RADIUS_BITS'($urandom_range(1, 12)), 400);
        end

        // drain, then leave room for any stray word
        while (words_to_send.size() != 0 || in_valid || points_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (faults == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    // Run limit
    initial
    begin
        #(64'd10_000_000);
        $display("tb: failure");
        $finish;
    end

    // Driver: record accepted words, then offer the next one after its gap
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            req_type <= REQ_STEP;
            center_x <= '0;
            center_y <= '0;
            radius_a <= '0;
            radius_b <= '0;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                ellipse_next(track_st, req_type, center_x, center_y,
                             radius_a, radius_b, due_set);
                points_due.push_back(due_set);
            end
            if (!in_valid || in_ready)
            begin
                if (words_to_send.size() == 0)
                    in_valid <= 1'b0;
                else if (words_to_send[0].drain && points_due.size() != 0)
                    in_valid <= 1'b0;
                else if (words_to_send[0].gap != 0)
                begin
                    words_to_send[0].gap = words_to_send[0].gap - 1;
                    in_valid <= 1'b0;
                end
                else
                begin
                    in_valid <= 1'b1;
                    req_type <= words_to_send[0].req;
                    center_x <= words_to_send[0].cx;
                    center_y <= words_to_send[0].cy;
                    radius_a <= words_to_send[0].ra;
                    radius_b <= words_to_send[0].rb;
                    void'(words_to_send.pop_front());
                end
            end
        end
    end

    // Receiver: random stalls, calm stretches, and two long hold-offs
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready  <= 1'b0;
            stall_left <= 0;
            calm_left  <= 0;
            hold_phase <= 0;
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
        end
        else if (hold_phase < 2 && words_seen >= (hold_phase == 0 ? 60 : 450))
        begin
            hold_phase <= hold_phase + 1;
            stall_left <= LONG_HOLD;
            out_ready  <= 1'b0;
        end
        else if (calm_left != 0)
        begin
            calm_left <= calm_left - 1;
            out_ready <= 1'b1;
        end
        else if ($urandom_range(0, 29) == 0)
        begin
            calm_left <= $urandom_range(20, 80);
            out_ready <= 1'b1;
        end
        else if ($urandom_range(0, 2) == 0)
        begin
            stall_left <= pick_idle();
            out_ready  <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // Monitor: check each delivered word against the oldest expected point
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            words_seen <= 0;
        else if (out_valid && out_ready)
        begin
            words_seen <= words_seen + 1;
            got = {point_valid, x_plus, x_minus, y_plus, y_minus, last_point};
            if (points_due.size() == 0)
            begin
                faults = faults + 1;
                if (faults <= 10)
                    $display("word %0d delivered with none expected", words_seen);
            end
            else
            begin
                want = points_due.pop_front();
                if (got.pv !== want.pv || got.xp !== want.xp || got.xm !== want.xm ||
                    got.yp !== want.yp || got.ym !== want.ym || got.last !== want.last)
                begin
                    faults = faults + 1;
                    if (faults <= 10)
                        $display("word %0d: want pv=%b x+=%h x-=%h y+=%h y-=%h last=%b",
                                 words_seen, want.pv, want.xp, want.xm, want.yp, want.ym,
                                 want.last, "\n         got  pv=%b x+=%h x-=%h y+=%h",
                                 got.pv, got.xp, got.xm, got.yp,
                                 " y-=%h last=%b", got.ym, got.last);
                end
            end
        end
    end

endmodule

`default_nettype wire
